@@ hdl/wav_riff_header_parser_defines.svh @@
// assertion macros for the riff/wave header parser
// used by wav_riff_header_parser; expects clk and rst in scope
`ifndef WAV_RIFF_HEADER_PARSER_DEFINES_SVH
`define WAV_RIFF_HEADER_PARSER_DEFINES_SVH

// same-cycle implication
`define WRHP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define WRHP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ hdl/wrhp_pkg.sv @@
// types and constants for the riff/wave header parser
// no dependencies
`timescale 1ns / 1ps

package wrhp_pkg;

  localparam int unsigned FmtBytes = 16;

  localparam logic [31:0] ID_FMT  = 32'h666D_7420;
  localparam logic [31:0] ID_DATA = 32'h6461_7461;
  localparam logic [31:0] DEFAULT_RATE = 32'd22050;
  localparam logic [15:0] TAG_PCM = 16'd1;
  localparam logic [15:0] BITS_16 = 16'd16;

  localparam logic [7:0] RIFF_MAGIC [12] = '{
    8'h52, 8'h49, 8'h46, 8'h46, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h57, 8'h41, 8'h56, 8'h45
  };

  localparam int unsigned OUT_DATA_BITS = 136;

  // fmt capture slot: count has bit 4 set when idle
  typedef struct packed {
    logic [4:0]      count;
    logic [7:0][7:0] lo;
    logic [7:0]      b14;
  } cap_slot_t;

  typedef struct packed {
    logic        parse_ok;
    logic        sixteen_bit;
    logic [15:0] channel_count;
    logic [31:0] sample_rate;
    logic [15:0] format_tag;
    logic [31:0] data_offset;
    logic [31:0] data_length;
  } result_t;

endpackage

@@ hdl/wav_riff_header_parser.sv @@
// riff/wave header parser top level
// depends on wrhp_pkg and wav_riff_header_parser_defines.svh
`timescale 1ns / 1ps
`include "wav_riff_header_parser_defines.svh"

// Takes one file byte per request on the slave stream and reports the parsed
// format once, on the byte marked by tlast. An input register feeds the chunk
// walker, which updates its counters and compares combinationally and writes
// the result register, so one byte is taken every clock unless the slave side
// stalls. The report is registered from the final byte in the input register
// when the result register is free; a final byte that meets an unread report
// waits in the input register and stalls the slave side until that report is
// taken. Parser state is reset after each final byte, ready for the next file.
module wav_riff_header_parser #(
  parameter int unsigned POSITION_WIDTH = 32
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  logic [7:0]                            s_axis_tdata,  // file_byte
  input  logic                                  s_axis_tlast,  // end_of_file
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // parse_ok, sixteen_bit, channel_count, sample_rate, format_tag,
  // data_offset, data_length, zero fill
  output logic [wrhp_pkg::OUT_DATA_BITS-1:0]    m_axis_tdata
);

  localparam int unsigned PW = POSITION_WIDTH;
  localparam int unsigned EW = POSITION_WIDTH + 32;

  // input register
  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_last;
  logic       go;

  // parser state
  logic [PW-1:0]           position, position_next;
  logic                    header_valid, header_valid_next;
  logic [63:0]             shift, shift_next;
  logic [2:0]              hcnt, hcnt_next;
  logic [32:0]             skip, skip_next;
  wrhp_pkg::cap_slot_t     cap [2];
  wrhp_pkg::cap_slot_t     cap_next [2];
  logic [15:0]             fmt_tag, fmt_tag_next;
  logic [15:0]             fmt_channels, fmt_channels_next;
  logic [31:0]             fmt_rate, fmt_rate_next;
  logic                    fmt_sixteen, fmt_sixteen_next;
  logic                    data_found, data_found_next;
  logic [PW-1:0]           data_off, data_off_next;
  logic [31:0]             data_len, data_len_next;

  wrhp_pkg::result_t       result;

  assign go = s1_valid && (!s1_last || !m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !s1_valid || go;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid <= s_axis_tvalid;
    end
    if (s_axis_tready) begin
      s1_byte <= s_axis_tdata;
      s1_last <= s_axis_tlast;
    end
  end

  // chunk walker and fmt capture
  always_comb begin
    logic [7:0]  v;
    logic [31:0] id;
    logic [31:0] len;
    logic        fmt_hit;
    v       = s1_byte;
    id      = '0;
    len     = '0;
    fmt_hit = 1'b0;

    position_next     = (position == {PW{1'b1}}) ? position : position + PW'(1);
    header_valid_next = header_valid;
    shift_next        = shift;
    hcnt_next         = hcnt;
    skip_next         = skip;
    fmt_tag_next      = fmt_tag;
    fmt_channels_next = fmt_channels;
    fmt_rate_next     = fmt_rate;
    fmt_sixteen_next  = fmt_sixteen;
    data_found_next   = data_found;
    data_off_next     = data_off;
    data_len_next     = data_len;

    if (position < PW'(12)) begin
      if (position[3:0] inside {[4'd0:4'd3], [4'd8:4'd11]}) begin
        if (v != wrhp_pkg::RIFF_MAGIC[position[3:0]]) begin
          header_valid_next = 1'b0;
        end
      end
    end else if (header_valid) begin
      if (skip != '0) begin
        skip_next = skip - 33'd1;
      end else begin
        shift_next = {shift[55:0], v};
        if (hcnt == 3'd7) begin
          hcnt_next = '0;
          id  = shift_next[63:32];
          len = {shift_next[7:0], shift_next[15:8], shift_next[23:16], shift_next[31:24]};
          if (id == wrhp_pkg::ID_FMT) begin
            fmt_hit = 1'b1;
          end else if (id == wrhp_pkg::ID_DATA) begin
            data_found_next = 1'b1;
            data_off_next   = position_next;
            data_len_next   = len;
          end
          skip_next = {1'b0, len} + {32'b0, len[0]};
        end else begin
          hcnt_next = hcnt + 3'd1;
        end
      end
    end

    for (int i = 0; i < 2; i++) begin
      cap_next[i] = cap[i];
      if (!cap[i].count[4]) begin
        if (!cap[i].count[3]) begin
          cap_next[i].lo[cap[i].count[2:0]] = v;
        end
        if (cap[i].count == 5'd14) begin
          cap_next[i].b14 = v;
        end
        if (cap[i].count == 5'(wrhp_pkg::FmtBytes - 1)) begin
          fmt_tag_next      = {cap[i].lo[1], cap[i].lo[0]};
          fmt_channels_next = {cap[i].lo[3], cap[i].lo[2]};
          fmt_rate_next     = {cap[i].lo[7], cap[i].lo[6], cap[i].lo[5], cap[i].lo[4]};
          fmt_sixteen_next  = ({v, cap[i].b14} == wrhp_pkg::BITS_16);
        end
        cap_next[i].count = cap[i].count + 5'd1;
      end
    end

    if (fmt_hit) begin
      if (cap_next[0].count[4]) begin
        cap_next[0].count = '0;
      end else if (cap_next[1].count[4]) begin
        cap_next[1].count = '0;
      end
    end
  end

  // result from the updated state
  always_comb begin
    logic [PW-1:0] rem;
    logic [EW-1:0] rem_ext;
    logic [EW-1:0] len_ext;
    logic [EW-1:0] off_ext;
    logic [31:0]   dlen;
    rem     = (position_next >= data_off_next) ? position_next - data_off_next : '0;
    rem_ext = {32'b0, rem};
    len_ext = {{PW{1'b0}}, data_len_next};
    off_ext = {32'b0, data_off_next};
    dlen    = '0;
    if (data_found_next) begin
      dlen = (rem_ext < len_ext) ? rem_ext[31:0] : data_len_next;
    end
    result.parse_ok      = (position_next >= PW'(12)) && header_valid_next &&
                           (fmt_tag_next == wrhp_pkg::TAG_PCM) && data_found_next &&
                           (dlen != '0) && (fmt_channels_next != '0);
    result.sixteen_bit   = fmt_sixteen_next;
    result.channel_count = fmt_channels_next;
    result.sample_rate   = (fmt_rate_next != '0) ? fmt_rate_next : wrhp_pkg::DEFAULT_RATE;
    result.format_tag    = fmt_tag_next;
    result.data_offset   = data_found_next ? off_ext[31:0] : '0;
    result.data_length   = dlen;
  end

  always_ff @(posedge clk) begin
    if (rst || (go && s1_last)) begin
      position     <= '0;
      header_valid <= 1'b1;
      shift        <= '0;
      hcnt         <= '0;
      skip         <= '0;
      for (int i = 0; i < 2; i++) begin
        cap[i].count <= 5'(wrhp_pkg::FmtBytes);
      end
      fmt_tag      <= wrhp_pkg::TAG_PCM;
      fmt_channels <= 16'd1;
      fmt_rate     <= wrhp_pkg::DEFAULT_RATE;
      fmt_sixteen  <= 1'b0;
      data_found   <= 1'b0;
      data_off     <= '0;
      data_len     <= '0;
    end else if (go) begin
      position     <= position_next;
      header_valid <= header_valid_next;
      shift        <= shift_next;
      hcnt         <= hcnt_next;
      skip         <= skip_next;
      for (int i = 0; i < 2; i++) begin
        cap[i].count <= cap_next[i].count;
      end
      fmt_tag      <= fmt_tag_next;
      fmt_channels <= fmt_channels_next;
      fmt_rate     <= fmt_rate_next;
      fmt_sixteen  <= fmt_sixteen_next;
      data_found   <= data_found_next;
      data_off     <= data_off_next;
      data_len     <= data_len_next;
    end
    if (go) begin
      for (int i = 0; i < 2; i++) begin
        cap[i].lo  <= cap_next[i].lo;
        cap[i].b14 <= cap_next[i].b14;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (go && s1_last) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
    if (go && s1_last) begin
      m_axis_tdata <= {6'b0, result.data_length, result.data_offset, result.format_tag,
                       result.sample_rate, result.channel_count, result.sixteen_bit,
                       result.parse_ok};
    end
  end

  `WRHP_ASSERT_IMP(a_cap_distinct, !cap[0].count[4] && !cap[1].count[4], cap[0].count != cap[1].count, "two fmt captures share a count")
  `WRHP_ASSERT_IMP(a_hdr_no_skip, hcnt != 3'd0, skip == 33'd0, "chunk header collected while skipping")
  `WRHP_ASSERT_NXT(a_last_result, go && s1_last, m_axis_tvalid, "final byte gave no result")
  `WRHP_ASSERT_NXT(a_last_clear, go && s1_last, position == '0 && header_valid, "state not cleared after final byte")

endmodule
